[src/ffwa_pkg.sv]
// shared constants, codes and types of the flash frame wear accounting block
package ffwa_pkg;

    localparam int MAX_FRAMES    = 65536;
    localparam int MAX_ORDER_LOG = 10;

    localparam int FRAME_AW = $clog2(MAX_FRAMES);
    localparam int CNT_W    = FRAME_AW + 1;
    localparam int WALK_W   = (CNT_W > MAX_ORDER_LOG + 1) ? CNT_W : MAX_ORDER_LOG + 1;

    localparam int FUNC_W  = 3;
    localparam int ADDR_W  = 40;
    localparam int ORDER_W = 4;
    localparam int PAGES_W = 11;
    localparam int COUNT_W = 17;
    localparam int WEAR_W  = 32;
    localparam int TALLY_W = 48;
    localparam int OFF_W   = ADDR_W + 2;

    localparam logic [WEAR_W-1:0] U32_MAX = '1;

    localparam int TAG_MIG_BIT = 0;
    localparam int TAG_WR_BIT  = 1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 3'd0,
        FN_FAULT   = 3'd1,
        FN_MIG_IN  = 3'd2,
        FN_BACK    = 3'd3,
        FN_STATS   = 3'd4,
        FN_CLEAR   = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        tag;
        logic [WEAR_W-1:0] wear;
    } t_frame_entry;

    typedef struct packed {
        logic clr;
        logic en;
    } t_stats_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]   nz;
        logic [WEAR_W-1:0]  mn;
        logic [WEAR_W-1:0]  mx;
        logic [TALLY_W-1:0] sum;
    } t_stats_res;

endpackage

[src/ffwa_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
module ffwa_ram #(
    parameter int WIDTH = 34,
    parameter int AW    = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ffwa_stats.sv]
// running count, min, max of nonzero wear values, saturating sum of all
module ffwa_stats (
    input  logic                              i_clk,
    input  ffwa_pkg::t_stats_ctl              i_ctl,
    input  logic [ffwa_pkg::WEAR_W-1:0]       i_wear,
    output ffwa_pkg::t_stats_res              o_res
);
    import ffwa_pkg::*;

    logic [CNT_W-1:0]   r_nz;
    logic [WEAR_W-1:0]  r_mn;
    logic [WEAR_W-1:0]  r_mx;
    logic [TALLY_W-1:0] r_sum;
    logic [TALLY_W:0]   sum_ext;

    assign sum_ext = {1'b0, r_sum} + (TALLY_W + 1)'(i_wear);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_nz  <= '0;
            r_mn  <= U32_MAX;
            r_mx  <= '0;
            r_sum <= '0;
        end else if (i_ctl.en) begin
            r_sum <= sum_ext[TALLY_W] ? '1 : sum_ext[TALLY_W-1:0];
            if (i_wear != '0) begin
                r_nz <= r_nz + CNT_W'(1);
                if (i_wear < r_mn) begin
                    r_mn <= i_wear;
                end
                if (i_wear > r_mx) begin
                    r_mx <= i_wear;
                end
            end
        end
    end

    // minimum reads as zero when no frame was programmed
    always_comb begin
        o_res.nz  = r_nz;
        o_res.mn  = (r_nz == '0) ? '0 : r_mn;
        o_res.mx  = r_mx;
        o_res.sum = r_sum;
    end

endmodule

[src/flash_frame_wear_accounting.sv]
// top level: sequencer, tallies and frame store of the flash frame wear accounting block
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_func, i_page_frame, i_order, ...
//  out     | o_out_valid | i_out_stall | o_alloc_programs ... o_fault_counted
//  cfg     | i_cfg_wr_en | -           | i_cfg_idx, i_cfg_wr_data
//
//  one transaction at a time; the frame ram has one read and one write port and
//  walks one frame per cycle: alloc 2^order frames (order capped at 10), fault and
//  migrated back one, migrated in and unused codes none, stats the span (none for
//  an empty span), clear all MAX_FRAMES frames in a wipe
//  after reset a wipe of all MAX_FRAMES ram entries runs with o_in_stall high
//  a finished result sits in the output register; the next transaction is taken
//  meanwhile and only its completion waits for i_out_stall to drop
module flash_frame_wear_accounting (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_idx,
    input  logic [ffwa_pkg::ADDR_W-1:0]       i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ffwa_pkg::FUNC_W-1:0]       i_func,
    input  logic [ffwa_pkg::ADDR_W-1:0]       i_page_frame,
    input  logic [ffwa_pkg::ORDER_W-1:0]      i_order,
    input  logic                              i_migrated_context,
    input  logic [ffwa_pkg::PAGES_W-1:0]      i_page_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_alloc_programs,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_migrated_in_pages,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_back_of_alloc,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_back_of_migrated,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_written_of_alloc,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_written_of_migrated,
    output logic [ffwa_pkg::COUNT_W-1:0]      o_frames_programmed,
    output logic [ffwa_pkg::WEAR_W-1:0]       o_erase_min,
    output logic [ffwa_pkg::WEAR_W-1:0]       o_erase_max,
    output logic [ffwa_pkg::TALLY_W-1:0]      o_erase_sum,
    output logic                              o_fault_counted
);
    import ffwa_pkg::*;

    localparam int ENTRY_W = $bits(t_frame_entry);

    // control state
    t_state              r_state, n_state;
    logic                r_boot, n_boot;
    logic [WALK_W-1:0]   r_i, n_i;
    logic                r_p_valid, n_p_valid;
    logic                r_out_valid, n_out_valid;
    logic [TALLY_W-1:0]  r_prog, n_prog;
    logic [TALLY_W-1:0]  r_mig_in, n_mig_in;
    logic [TALLY_W-1:0]  r_back_a, n_back_a;
    logic [TALLY_W-1:0]  r_back_m, n_back_m;
    logic [TALLY_W-1:0]  r_flt_a, n_flt_a;
    logic [TALLY_W-1:0]  r_flt_m, n_flt_m;
    logic [ADDR_W-1:0]   r_base;
    logic [COUNT_W-1:0]  r_count;

    // per-transaction payload
    t_func               r_func, n_func;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [WALK_W-1:0]   r_last, n_last;
    logic                r_origin, n_origin;
    logic [PAGES_W-1:0]  r_pages, n_pages;
    logic                r_counted, n_counted;
    logic                r_p_do, n_p_do;
    logic [FRAME_AW-1:0] r_p_addr, n_p_addr;

    // output register payload
    logic [TALLY_W-1:0]  r_o_prog, n_o_prog;
    logic [TALLY_W-1:0]  r_o_mig_in, n_o_mig_in;
    logic [TALLY_W-1:0]  r_o_back_a, n_o_back_a;
    logic [TALLY_W-1:0]  r_o_back_m, n_o_back_m;
    logic [TALLY_W-1:0]  r_o_flt_a, n_o_flt_a;
    logic [TALLY_W-1:0]  r_o_flt_m, n_o_flt_m;
    logic [COUNT_W-1:0]  r_o_nz, n_o_nz;
    logic [WEAR_W-1:0]   r_o_mn, n_o_mn;
    logic [WEAR_W-1:0]   r_o_mx, n_o_mx;
    logic [TALLY_W-1:0]  r_o_sum, n_o_sum;
    logic                r_o_counted, n_o_counted;

    logic                ram_we;
    logic [FRAME_AW-1:0] ram_waddr;
    t_frame_entry        ram_wentry;
    logic                ram_re;
    logic [FRAME_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_frame_entry        rd_entry;

    t_stats_ctl          stats_ctl;
    t_stats_res          stats_res;

    logic [CNT_W-1:0]    span;
    logic                off_in_span;
    logic [4:0]          ord;
    logic [WALK_W-1:0]   alloc_n;
    logic                out_free;

    ffwa_ram #(
        .WIDTH (ENTRY_W),
        .AW    (FRAME_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ENTRY_W'(ram_wentry)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffwa_stats u_stats (
        .i_clk  (i_clk),
        .i_ctl  (stats_ctl),
        .i_wear (rd_entry.wear),
        .o_res  (stats_res)
    );

    assign rd_entry = t_frame_entry'(ram_rdata);

    // tracked span: frame_count saturated at the store depth
    assign span = (32'(r_count) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : CNT_W'(r_count);

    // set when the current frame's offset from base is neither negative nor span or above
    assign off_in_span = (r_off[OFF_W-1:CNT_W] == '0) && (r_off[CNT_W-1:0] < span);

    assign ord     = (5'(i_order) > 5'(MAX_ORDER_LOG)) ? 5'(MAX_ORDER_LOG) : 5'(i_order);
    assign alloc_n = WALK_W'(1) << ord;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_boot      = r_boot;
        n_i         = r_i;
        n_p_valid   = 1'b0;
        n_p_do      = r_p_do;
        n_p_addr    = r_p_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_prog      = r_prog;
        n_mig_in    = r_mig_in;
        n_back_a    = r_back_a;
        n_back_m    = r_back_m;
        n_flt_a     = r_flt_a;
        n_flt_m     = r_flt_m;
        n_func      = r_func;
        n_off       = r_off;
        n_last      = r_last;
        n_origin    = r_origin;
        n_pages     = r_pages;
        n_counted   = r_counted;
        n_o_prog    = r_o_prog;
        n_o_mig_in  = r_o_mig_in;
        n_o_back_a  = r_o_back_a;
        n_o_back_m  = r_o_back_m;
        n_o_flt_a   = r_o_flt_a;
        n_o_flt_m   = r_o_flt_m;
        n_o_nz      = r_o_nz;
        n_o_mn      = r_o_mn;
        n_o_mx      = r_o_mx;
        n_o_sum     = r_o_sum;
        n_o_counted = r_o_counted;
        ram_we      = 1'b0;
        ram_waddr   = r_p_addr;
        ram_wentry  = rd_entry;
        ram_re      = 1'b0;
        ram_raddr   = r_off[FRAME_AW-1:0];
        stats_ctl   = '{clr: 1'b0, en: 1'b0};

        case (r_state)
            S_WIPE: begin
                ram_we     = 1'b1;
                ram_waddr  = r_i[FRAME_AW-1:0];
                ram_wentry = '0;
                n_i        = r_i + WALK_W'(1);
                if (r_i == WALK_W'(MAX_FRAMES - 1)) begin
                    n_state = r_boot ? S_IDLE : S_DONE;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = t_func'(i_func);
                    n_off     = OFF_W'({2'b00, i_page_frame}) - OFF_W'({2'b00, r_base});
                    n_origin  = i_migrated_context;
                    n_pages   = i_page_count;
                    n_counted = 1'b0;
                    n_i       = '0;
                    n_last    = '0;
                    case (t_func'(i_func))
                        FN_ALLOC: begin
                            n_last  = alloc_n - WALK_W'(1);
                            n_prog  = r_prog + TALLY_W'(alloc_n);
                            n_state = S_WALK;
                        end
                        FN_FAULT, FN_BACK: begin
                            n_state = S_WALK;
                        end
                        FN_MIG_IN: begin
                            n_mig_in = r_mig_in + TALLY_W'(i_page_count);
                            n_state  = S_DONE;
                        end
                        FN_STATS: begin
                            stats_ctl.clr = 1'b1;
                            n_last        = WALK_W'(span) - WALK_W'(1);
                            n_state       = (span == '0) ? S_DONE : S_WALK;
                        end
                        FN_CLEAR: begin
                            n_prog   = '0;
                            n_mig_in = '0;
                            n_back_a = '0;
                            n_back_m = '0;
                            n_flt_a  = '0;
                            n_flt_m  = '0;
                            n_boot   = 1'b0;
                            n_state  = S_WIPE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // issue the read of one frame; its write-back follows in the next cycle
                n_p_valid = 1'b1;
                if (r_func == FN_STATS) begin
                    ram_raddr = r_i[FRAME_AW-1:0];
                    n_p_do    = 1'b1;
                end else begin
                    n_p_do    = off_in_span;
                end
                ram_re   = n_p_do;
                n_p_addr = ram_raddr;
                n_off    = r_off + OFF_W'(1);
                n_i      = r_i + WALK_W'(1);
                if (r_i == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_prog    = r_prog;
                    n_o_mig_in  = r_mig_in;
                    n_o_back_a  = r_back_a;
                    n_o_back_m  = r_back_m;
                    n_o_flt_a   = r_flt_a;
                    n_o_flt_m   = r_flt_m;
                    n_o_counted = r_counted;
                    if (r_func == FN_STATS) begin
                        n_o_nz  = COUNT_W'(stats_res.nz);
                        n_o_mn  = stats_res.mn;
                        n_o_mx  = stats_res.mx;
                        n_o_sum = stats_res.sum;
                    end else begin
                        n_o_nz  = '0;
                        n_o_mn  = '0;
                        n_o_mx  = '0;
                        n_o_sum = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // write-back stage, fed by the read issued in the previous cycle
        if (r_p_valid) begin
            case (r_func)
                FN_ALLOC: begin
                    if (r_p_do) begin
                        ram_we          = 1'b1;
                        ram_wentry.wear = (rd_entry.wear == U32_MAX) ? rd_entry.wear
                                                                     : rd_entry.wear + 32'd1;
                        ram_wentry.tag  = {1'b0, r_origin};
                    end
                end
                FN_FAULT: begin
                    if (r_p_do && !rd_entry.tag[TAG_WR_BIT]) begin
                        ram_we                     = 1'b1;
                        ram_wentry.tag[TAG_WR_BIT] = 1'b1;
                        n_counted                  = 1'b1;
                        if (rd_entry.tag[TAG_MIG_BIT]) begin
                            n_flt_m = r_flt_m + TALLY_W'(1);
                        end else begin
                            n_flt_a = r_flt_a + TALLY_W'(1);
                        end
                    end
                end
                FN_BACK: begin
                    if (r_p_do && rd_entry.tag[TAG_MIG_BIT]) begin
                        n_back_m = r_back_m + TALLY_W'(r_pages);
                    end else begin
                        n_back_a = r_back_a + TALLY_W'(r_pages);
                    end
                end
                FN_STATS: begin
                    stats_ctl.en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_boot      <= 1'b1;
            r_i         <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_prog      <= '0;
            r_mig_in    <= '0;
            r_back_a    <= '0;
            r_back_m    <= '0;
            r_flt_a     <= '0;
            r_flt_m     <= '0;
            r_base      <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_boot      <= n_boot;
            r_i         <= n_i;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
            r_prog      <= n_prog;
            r_mig_in    <= n_mig_in;
            r_back_a    <= n_back_a;
            r_back_m    <= n_back_m;
            r_flt_a     <= n_flt_a;
            r_flt_m     <= n_flt_m;
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_BASE) begin
                    r_base <= i_cfg_wr_data;
                end else if (i_cfg_idx == CFG_COUNT) begin
                    r_count <= i_cfg_wr_data[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_off       <= n_off;
        r_last      <= n_last;
        r_origin    <= n_origin;
        r_pages     <= n_pages;
        r_counted   <= n_counted;
        r_p_do      <= n_p_do;
        r_p_addr    <= n_p_addr;
        r_o_prog    <= n_o_prog;
        r_o_mig_in  <= n_o_mig_in;
        r_o_back_a  <= n_o_back_a;
        r_o_back_m  <= n_o_back_m;
        r_o_flt_a   <= n_o_flt_a;
        r_o_flt_m   <= n_o_flt_m;
        r_o_nz      <= n_o_nz;
        r_o_mn      <= n_o_mn;
        r_o_mx      <= n_o_mx;
        r_o_sum     <= n_o_sum;
        r_o_counted <= n_o_counted;
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_alloc_programs      = r_o_prog;
    assign o_migrated_in_pages   = r_o_mig_in;
    assign o_back_of_alloc       = r_o_back_a;
    assign o_back_of_migrated    = r_o_back_m;
    assign o_written_of_alloc    = r_o_flt_a;
    assign o_written_of_migrated = r_o_flt_m;
    assign o_frames_programmed   = r_o_nz;
    assign o_erase_min           = r_o_mn;
    assign o_erase_max           = r_o_mx;
    assign o_erase_sum           = r_o_sum;
    assign o_fault_counted       = r_o_counted;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// testbench for the flash frame wear accounting block: directed and random transactions
module tb_top;
    import ffwa_pkg::*;

    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;
    localparam longint unsigned SUM_CEIL = (64'd1 << TALLY_W) - 1;
    localparam int unsigned IDLE_PCT = 27;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  frame;
        logic [ORDER_W-1:0] order;
        logic               mctx;
        logic [PAGES_W-1:0] pages;
    } t_frame_req;

    typedef struct packed {
        logic [TALLY_W-1:0] programs;
        logic [TALLY_W-1:0] mig_in;
        logic [TALLY_W-1:0] back_alloc;
        logic [TALLY_W-1:0] back_mig;
        logic [TALLY_W-1:0] fault_alloc;
        logic [TALLY_W-1:0] fault_mig;
        logic [COUNT_W-1:0] nz;
        logic [WEAR_W-1:0]  mn;
        logic [WEAR_W-1:0]  mx;
        logic [TALLY_W-1:0] sum;
        logic               counted;
    } t_wear_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic                i_cfg_idx = CFG_BASE;
    logic [ADDR_W-1:0]   i_cfg_wr_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [FUNC_W-1:0]   i_func = FN_STATS;
    logic [ADDR_W-1:0]   i_page_frame = '0;
    logic [ORDER_W-1:0]  i_order = '0;
    logic                i_migrated_context = 1'b0;
    logic [PAGES_W-1:0]  i_page_count = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [TALLY_W-1:0]  o_alloc_programs;
    logic [TALLY_W-1:0]  o_migrated_in_pages;
    logic [TALLY_W-1:0]  o_back_of_alloc;
    logic [TALLY_W-1:0]  o_back_of_migrated;
    logic [TALLY_W-1:0]  o_written_of_alloc;
    logic [TALLY_W-1:0]  o_written_of_migrated;
    logic [COUNT_W-1:0]  o_frames_programmed;
    logic [WEAR_W-1:0]   o_erase_min;
    logic [WEAR_W-1:0]   o_erase_max;
    logic [TALLY_W-1:0]  o_erase_sum;
    logic                o_fault_counted;

    // behavioral copy of the frame stores, tallies and span registers
    bit [WEAR_W-1:0]  wear_of [MAX_FRAMES];
    bit [1:0]         tag_of [MAX_FRAMES];
    bit [TALLY_W-1:0] programs, mig_in, back_alloc, back_mig, fault_alloc, fault_mig;
    bit [ADDR_W-1:0]  span_base;
    bit [COUNT_W-1:0] span_count;

    t_wear_report pending_reports[$];
    int unsigned  mismatches = 0;
    int unsigned  gap_pct = IDLE_PCT;
    int unsigned  stall_pct = IDLE_PCT;
    int unsigned  clears_left = 2;

    flash_frame_wear_accounting u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_wr_data         (i_cfg_wr_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_func                (i_func),
        .i_page_frame          (i_page_frame),
        .i_order               (i_order),
        .i_migrated_context    (i_migrated_context),
        .i_page_count          (i_page_count),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_alloc_programs      (o_alloc_programs),
        .o_migrated_in_pages   (o_migrated_in_pages),
        .o_back_of_alloc       (o_back_of_alloc),
        .o_back_of_migrated    (o_back_of_migrated),
        .o_written_of_alloc    (o_written_of_alloc),
        .o_written_of_migrated (o_written_of_migrated),
        .o_frames_programmed   (o_frames_programmed),
        .o_erase_min           (o_erase_min),
        .o_erase_max           (o_erase_max),
        .o_erase_sum           (o_erase_sum),
        .o_fault_counted       (o_fault_counted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned tracked_len();
        return (span_count > MAX_FRAMES) ? MAX_FRAMES : span_count;
    endfunction

    function automatic bit lookup_index(input longint unsigned frame, output int unsigned idx);
        idx = 0;
        if (frame < span_base) return 1'b0;
        if (frame - span_base >= tracked_len()) return 1'b0;
        idx = 32'(frame - span_base);
        return 1'b1;
    endfunction

    function automatic t_wear_report account_item(input t_frame_req rq);
        t_wear_report    rep;
        longint unsigned n;
        longint unsigned sum;
        longint unsigned c;
        int unsigned     idx;
        int unsigned     ord;
        rep = '0;
        case (rq.func)
            FN_ALLOC: begin
                ord = (rq.order > MAX_ORDER_LOG) ? MAX_ORDER_LOG : rq.order;
                n = 64'd1 << ord;
                for (longint unsigned i = 0; i < n; i++) begin
                    if (lookup_index(rq.frame + i, idx)) begin
                        if (wear_of[idx] != U32_MAX) wear_of[idx]++;
                        tag_of[idx] = '0;
                        tag_of[idx][TAG_MIG_BIT] = rq.mctx;
                    end
                end
                programs += n[TALLY_W-1:0];
            end
            FN_FAULT: begin
                // only the first write fault of an occupant counts
                if (lookup_index(rq.frame, idx) && !tag_of[idx][TAG_WR_BIT]) begin
                    tag_of[idx][TAG_WR_BIT] = 1'b1;
                    if (tag_of[idx][TAG_MIG_BIT]) fault_mig++;
                    else fault_alloc++;
                    rep.counted = 1'b1;
                end
            end
            FN_MIG_IN: mig_in += TALLY_W'(rq.pages);
            FN_BACK: begin
                if (lookup_index(rq.frame, idx) && tag_of[idx][TAG_MIG_BIT])
                    back_mig += TALLY_W'(rq.pages);
                else
                    back_alloc += TALLY_W'(rq.pages);
            end
            FN_STATS: begin
                sum = 0;
                rep.mn = U32_MAX;
                for (int unsigned k = 0; k < tracked_len(); k++) begin
                    c = 64'(wear_of[k]);
                    sum += c;
                    if (sum > SUM_CEIL) sum = SUM_CEIL;
                    if (c != 0) begin
                        rep.nz++;
                        if (c < rep.mn) rep.mn = c[WEAR_W-1:0];
                        if (c > rep.mx) rep.mx = c[WEAR_W-1:0];
                    end
                end
                if (rep.nz == 0) rep.mn = '0;
                rep.sum = sum[TALLY_W-1:0];
            end
            FN_CLEAR: begin
                foreach (wear_of[k]) begin
                    wear_of[k] = '0;
                    tag_of[k] = '0;
                end
                programs = '0;
                mig_in = '0;
                back_alloc = '0;
                back_mig = '0;
                fault_alloc = '0;
                fault_mig = '0;
            end
            default: ;
        endcase
        rep.programs = programs;
        rep.mig_in = mig_in;
        rep.back_alloc = back_alloc;
        rep.back_mig = back_mig;
        rep.fault_alloc = fault_alloc;
        rep.fault_mig = fault_mig;
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [TALLY_W-1:0] want,
                                        input logic [TALLY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_wear_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result transaction with nothing outstanding");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("alloc_programs", want.programs, o_alloc_programs);
                check_field("migrated_in_pages", want.mig_in, o_migrated_in_pages);
                check_field("back_of_alloc", want.back_alloc, o_back_of_alloc);
                check_field("back_of_migrated", want.back_mig, o_back_of_migrated);
                check_field("written_of_alloc", want.fault_alloc, o_written_of_alloc);
                check_field("written_of_migrated", want.fault_mig, o_written_of_migrated);
                check_field("frames_programmed", TALLY_W'(want.nz),
                            TALLY_W'(o_frames_programmed));
                check_field("erase_min", TALLY_W'(want.mn), TALLY_W'(o_erase_min));
                check_field("erase_max", TALLY_W'(want.mx), TALLY_W'(o_erase_max));
                check_field("erase_sum", want.sum, o_erase_sum);
                check_field("fault_counted", TALLY_W'(want.counted), TALLY_W'(o_fault_counted));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [ADDR_W-1:0] rand40();
        return {8'($urandom_range(255)), 32'($urandom())};
    endfunction

    function automatic t_frame_req mk(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] frame,
                                      input logic [ORDER_W-1:0] order, input logic mctx,
                                      input logic [PAGES_W-1:0] pages);
        t_frame_req rq;
        rq.func = f;
        rq.frame = frame;
        rq.order = order;
        rq.mctx = mctx;
        rq.pages = pages;
        return rq;
    endfunction

    // drive one transaction and record what it should produce once accepted
    task automatic issue(input t_frame_req rq);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_in_valid <= 1'b1;
        i_func <= rq.func;
        i_page_frame <= rq.frame;
        i_order <= rq.order;
        i_migrated_context <= rq.mctx;
        i_page_count <= rq.pages;
        do @(posedge i_clk); while (o_in_stall);
        pending_reports.push_back(account_item(rq));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic set_span(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] count);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= CFG_BASE;
        i_cfg_wr_data <= base;
        @(posedge i_clk);
        i_cfg_idx <= CFG_COUNT;
        i_cfg_wr_data <= ADDR_W'(count);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        span_base = base;
        span_count = count;
    endtask

    function automatic t_frame_req random_req(input bit walks_ok);
        t_frame_req  rq;
        int unsigned pick;
        rq.mctx = 1'($urandom_range(1));
        rq.pages = ($urandom_range(9) == 0) ? PAGES_W'(1024) : PAGES_W'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 35) rq.func = FN_ALLOC;
        else if (pick < 60) rq.func = FN_FAULT;
        else if (pick < 68) rq.func = FN_MIG_IN;
        else if (pick < 84) rq.func = FN_BACK;
        else if (pick < 92) rq.func = walks_ok ? FN_STATS : FN_FAULT;
        else if (pick < 93) rq.func = (clears_left > 0) ? FN_CLEAR : FN_ALLOC;
        else if (pick < 96) rq.func = FN_RSVD_6;
        else rq.func = FN_RSVD_7;
        if (rq.func == FN_CLEAR) clears_left--;
        pick = $urandom_range(99);
        if (pick < 85) rq.frame = span_base + $urandom_range(span_count + 3);
        else if (pick < 93) rq.frame = span_base - $urandom_range(1, 4);
        else rq.frame = rand40();
        pick = $urandom_range(99);
        if (pick < 70) rq.order = ORDER_W'($urandom_range(2));
        else if (pick < 95) rq.order = ORDER_W'($urandom_range(3, 10));
        else rq.order = ORDER_W'($urandom_range(11, 15));
        return rq;
    endfunction

    task automatic run_random_phase(input int unsigned n, input bit idling, input bit walks_ok);
        gap_pct = idling ? IDLE_PCT : 0;
        stall_pct = idling ? IDLE_PCT : 0;
        for (int unsigned k = 0; k < n; k++) begin
            issue(random_req(walks_ok));
            // hold the sender off now and then until every result is back
            if (k % 40 == 39) drain();
        end
        gap_pct = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    task automatic test_directed_ops();
        set_span(40'h100, 17'd16);
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
        issue(mk(FN_ALLOC, 40'h100, 4'd0, 1'b0, '0));
        issue(mk(FN_ALLOC, 40'h10E, 4'd2, 1'b1, '0));
        issue(mk(FN_ALLOC, 40'h100, 4'd15, 1'b1, '1));
        issue(mk(FN_ALLOC, '0, 4'd0, 1'b0, '0));
        issue(mk(FN_FAULT, 40'h100, '0, 1'b0, '0));
        issue(mk(FN_FAULT, 40'h100, '0, 1'b0, '0));
        issue(mk(FN_FAULT, 40'h110, '0, 1'b0, '0));
        issue(mk(FN_FAULT, 40'h0FF, '0, 1'b0, '0));
        issue(mk(FN_FAULT, '1, '1, 1'b1, '1));
        issue(mk(FN_ALLOC, 40'h101, 4'd0, 1'b0, '0));
        issue(mk(FN_FAULT, 40'h101, '0, 1'b0, '0));
        issue(mk(FN_MIG_IN, 40'h100, '0, 1'b0, 11'd1024));
        issue(mk(FN_MIG_IN, 40'h100, '0, 1'b0, 11'd0));
        issue(mk(FN_BACK, 40'h100, '0, 1'b0, 11'd1024));
        issue(mk(FN_BACK, 40'h101, '0, 1'b0, 11'd1));
        issue(mk(FN_BACK, 40'h110, '0, 1'b1, 11'd7));
        issue(mk(FN_RSVD_6, rand40(), 4'd3, 1'b1, 11'd5));
        issue(mk(FN_RSVD_7, rand40(), 4'd9, 1'b0, 11'd1023));
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
        issue(mk(FN_CLEAR, '0, '0, 1'b0, '0));
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
    endtask

    task automatic test_span_extremes();
        // base at the top of the frame space, count above capacity
        set_span('1, '1);
        issue(mk(FN_ALLOC, '1, 4'd10, 1'b1, '0));
        issue(mk(FN_FAULT, '1, '0, 1'b0, '0));
        issue(mk(FN_BACK, '1, '0, 1'b0, 11'd3));
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
        // empty span tracks nothing
        set_span('0, '0);
        issue(mk(FN_ALLOC, '0, 4'd1, 1'b1, '0));
        issue(mk(FN_FAULT, '0, '0, 1'b0, '0));
        issue(mk(FN_BACK, '0, '0, 1'b0, 11'd5));
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
    endtask

    task automatic test_random_mixed();
        set_span(rand40(), COUNT_W'($urandom_range(1, 64)));
        run_random_phase(150, 1'b1, 1'b1);
    endtask

    task automatic test_calm_stretch();
        set_span(ADDR_W'($urandom_range(1000)), COUNT_W'($urandom_range(16, 200)));
        run_random_phase(150, 1'b0, 1'b1);
    endtask

    task automatic test_top_of_range();
        set_span('1 - ADDR_W'($urandom_range(200)), 17'd300);
        run_random_phase(150, 1'b1, 1'b1);
    endtask

    task automatic test_full_span();
        // stats walks are long here, so only one at the end
        set_span(rand40(), 17'd65536);
        run_random_phase(100, 1'b1, 1'b0);
        issue(mk(FN_STATS, '0, '0, 1'b0, '0));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // ram wipe after reset
        do @(posedge i_clk); while (o_in_stall);
        test_directed_ops();
        test_span_extremes();
        test_random_mixed();
        test_calm_stretch();
        test_top_of_range();
        test_full_span();
        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
